### hdl/timer_min_heap_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer heap queue
// Used by tmhq_seq, the module that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TIMER_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define TIMER_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define TMHQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tmhq: assertion failed");

// Next-cycle implication, clocked on aclk, off during reset
`define TMHQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tmhq: assertion failed");

`endif

### hdl/tmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_pkg
// Types and codes shared by the timer heap queue modules.
// ----------------------------------------------------------------------------
package tmhq_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_EXPIRE = 2'd2;
    localparam logic [1:0] CMD_WAIT   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE_DUE  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] time_now;
        logic [63:0] start_time;
        logic [31:0] interval;
        logic [15:0] handler_tag;
        logic [15:0] timer_id;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic        fired;
        logic [15:0] fired_tag;
        logic [31:0] wait_time;
    } result_t;

    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] period;
        logic [15:0] tag;
        logic [15:0] ident;
    } entry_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

### hdl/tmhq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_mem
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmhq_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  tmhq_pkg::entry_t         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output tmhq_pkg::entry_t         rd_data
);
    import tmhq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/tmhq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_seq
// Command sequencer: id search, sift-up, sift-down, expire and wait.
// ----------------------------------------------------------------------------
`include "timer_min_heap_queue_top_assert.svh"

module tmhq_seq #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_i,
    input  tmhq_pkg::item_t               item_i,
    input  logic                          out_free_i,
    output tmhq_pkg::seq_stat_t           stat_o,
    output tmhq_pkg::result_t             result_o,
    output logic                          mem_wr_en_o,
    output logic [$clog2(HEAP_DEPTH)-1:0] mem_wr_addr_o,
    output tmhq_pkg::entry_t              mem_wr_data_o,
    output logic [$clog2(HEAP_DEPTH)-1:0] mem_rd_addr_o,
    input  tmhq_pkg::entry_t              mem_rd_data_i
);
    import tmhq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SCAN    = 14'b00000000000010,
        S_SU_RD   = 14'b00000000000100,
        S_SU_CMP  = 14'b00000000001000,
        S_DROP_RD = 14'b00000000010000,
        S_DROP_LD = 14'b00000000100000,
        S_SD_LD   = 14'b00000001000000,
        S_SD_LD2  = 14'b00000010000000,
        S_SD_RL   = 14'b00000100000000,
        S_SD_RR   = 14'b00001000000000,
        S_SD_CMP  = 14'b00010000000000,
        S_EXP     = 14'b00100000000000,
        S_WAIT    = 14'b01000000000000,
        S_FIN     = 14'b10000000000000
    } state_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    result_t         res_reg, res_next;
    entry_t          node_reg, node_next;
    entry_t          left_reg, left_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   hole_reg, hole_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [15:0]     next_id_reg, next_id_next;
    logic [15:0]     cand_reg, cand_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [AW-1:0]   chk_idx_reg, chk_idx_next;
    logic            right_ok_reg, right_ok_next;

    logic [AW+1:0]   lw, rw, cnt_w;
    logic [AW-1:0]   pm1, par;
    logic [15:0]     key, cand_inc, cand_wrap;
    logic            match;
    logic [64:0]     sum65;
    logic [63:0]     diff;
    logic            take_right;
    entry_t          pick;
    logic [AW+1:0]   pick_idx;
    logic            done;

    assign lw        = {1'b0, pos_reg, 1'b1};
    assign rw        = lw + (AW+2)'(1);
    assign cnt_w     = (AW+2)'(count_reg);
    assign pm1       = pos_reg - AW'(1);
    assign par       = pm1 >> 1;
    assign key       = (item_reg.cmd == CMD_ADD) ? cand_reg : item_reg.timer_id;
    assign match     = chk_valid_reg && (mem_rd_data_i.ident == key);
    assign cand_inc  = cand_reg + 16'd1;
    assign cand_wrap = (cand_inc == 16'd0) ? 16'd1 : cand_inc;
    assign sum65     = {1'b0, mem_rd_data_i.deadline} + {33'd0, mem_rd_data_i.period};
    assign diff      = mem_rd_data_i.deadline - item_reg.time_now;
    assign take_right = right_ok_reg && (mem_rd_data_i.deadline < left_reg.deadline);
    assign pick      = take_right ? mem_rd_data_i : left_reg;
    assign pick_idx  = take_right ? rw : lw;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        node_next      = node_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        hole_next      = hole_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        cand_next      = cand_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        right_ok_next  = right_ok_reg;
        mem_rd_addr_o  = '0;
        mem_wr_en_o    = 1'b0;
        mem_wr_addr_o  = pos_reg;
        mem_wr_data_o  = node_reg;
        done           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start_i) begin
                    item_next = item_i;
                    res_next  = '0;
                    scan_next = '0;
                    case (item_i.cmd)
                        CMD_ADD: begin
                            cand_next = (next_id_reg == 16'd0) ? 16'd1 : next_id_reg;
                            if (count_reg == DEPTH_C) begin
                                res_next.status = ST_FULL;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        CMD_EXPIRE: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_NONE_DUE;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_EXP;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                res_next.wait_time = item_i.interval;
                                state_next         = S_FIN;
                            end else begin
                                state_next = S_WAIT;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (match) begin
                    if (item_reg.cmd == CMD_ADD) begin
                        // id in use: try the next one and rescan from the root
                        cand_next = cand_wrap;
                        scan_next = '0;
                    end else begin
                        hole_next  = chk_idx_reg;
                        count_next = count_reg - CW'(1);
                        if (CW'(chk_idx_reg) < count_reg - CW'(1)) begin
                            state_next = S_DROP_RD;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                end else if (scan_reg < count_reg) begin
                    mem_rd_addr_o  = scan_reg[AW-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[AW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end else if (item_reg.cmd == CMD_ADD) begin
                    res_next.new_id = cand_reg;
                    next_id_next    = cand_inc;
                    node_next.deadline = (item_reg.start_time != 64'd0) ?
                                         item_reg.start_time : item_reg.time_now;
                    node_next.period = item_reg.interval;
                    node_next.tag    = item_reg.handler_tag;
                    node_next.ident  = cand_reg;
                    pos_next         = count_reg[AW-1:0];
                    count_next       = count_reg + CW'(1);
                    state_next       = S_SU_RD;
                end else begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_FIN;
                end
            end

            S_SU_RD: begin
                if (pos_reg == '0) begin
                    mem_wr_en_o = 1'b1;
                    state_next  = (item_reg.cmd == CMD_ADD) ? S_FIN : S_SD_LD;
                end else begin
                    mem_rd_addr_o = par;
                    state_next    = S_SU_CMP;
                end
            end

            S_SU_CMP: begin
                mem_wr_en_o = 1'b1;
                if (mem_rd_data_i.deadline > node_reg.deadline) begin
                    mem_wr_data_o = mem_rd_data_i;
                    pos_next      = par;
                    state_next    = S_SU_RD;
                end else begin
                    state_next = (item_reg.cmd == CMD_ADD) ? S_FIN : S_SD_LD;
                end
            end

            S_DROP_RD: begin
                mem_rd_addr_o = count_reg[AW-1:0];
                state_next    = S_DROP_LD;
            end

            S_DROP_LD: begin
                node_next  = mem_rd_data_i;
                pos_next   = hole_reg;
                state_next = S_SU_RD;
            end

            S_SD_LD: begin
                mem_rd_addr_o = hole_reg;
                pos_next      = hole_reg;
                state_next    = S_SD_LD2;
            end

            S_SD_LD2: begin
                node_next  = mem_rd_data_i;
                state_next = S_SD_RL;
            end

            S_SD_RL: begin
                if (lw >= cnt_w) begin
                    mem_wr_en_o = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    mem_rd_addr_o = lw[AW-1:0];
                    state_next    = S_SD_RR;
                end
            end

            S_SD_RR: begin
                left_next     = mem_rd_data_i;
                right_ok_next = rw < cnt_w;
                mem_rd_addr_o = rw[AW-1:0];
                state_next    = S_SD_CMP;
            end

            S_SD_CMP: begin
                mem_wr_en_o = 1'b1;
                if (node_reg.deadline > pick.deadline) begin
                    mem_wr_data_o = pick;
                    pos_next      = pick_idx[AW-1:0];
                    state_next    = S_SD_RL;
                end else begin
                    state_next = S_FIN;
                end
            end

            S_EXP: begin
                if (mem_rd_data_i.deadline > item_reg.time_now) begin
                    res_next.status = ST_NONE_DUE;
                    state_next      = S_FIN;
                end else begin
                    res_next.fired     = 1'b1;
                    res_next.fired_tag = mem_rd_data_i.tag;
                    hole_next          = '0;
                    pos_next           = '0;
                    if (mem_rd_data_i.period == 32'd0) begin
                        count_next = count_reg - CW'(1);
                        state_next = (count_reg > CW'(1)) ? S_DROP_RD : S_FIN;
                    end else begin
                        node_next          = mem_rd_data_i;
                        node_next.deadline = sum65[64] ? '1 : sum65[63:0];
                        state_next         = S_SD_RL;
                    end
                end
            end

            S_WAIT: begin
                if (mem_rd_data_i.deadline > item_reg.time_now) begin
                    res_next.wait_time = (diff < {32'd0, item_reg.interval}) ?
                                         diff[31:0] : item_reg.interval;
                end
                state_next = S_FIN;
            end

            S_FIN: begin
                if (out_free_i) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= 16'd1;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            chk_valid_reg <= chk_valid_next;
        end
        item_reg     <= item_next;
        res_reg      <= res_next;
        node_reg     <= node_next;
        left_reg     <= left_next;
        pos_reg      <= pos_next;
        hole_reg     <= hole_next;
        cand_reg     <= cand_next;
        scan_reg     <= scan_next;
        chk_idx_reg  <= chk_idx_next;
        right_ok_reg <= right_ok_next;
    end

    assign stat_o.idle = (state_reg == S_IDLE);
    assign stat_o.done = done;
    assign result_o    = res_reg;

    `TMHQ_ASSERT_IMP(a_start_idle, start_i, state_reg == S_IDLE)
    `TMHQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `TMHQ_ASSERT_IMP(a_count_step, count_reg != $past(count_reg), (count_reg == $past(count_reg) + CW'(1)) || (count_reg == $past(count_reg) - CW'(1)))
    `TMHQ_ASSERT_NXT(a_done_idle, done, state_reg == S_IDLE)

endmodule

### hdl/timer_min_heap_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_queue_top
// Timer queue held as a binary min-heap on deadline in one entry memory.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload         | handshake
//  s_      | in  | tmhq_pkg::item_t     | s_valid / s_ready
//  m_      | out | tmhq_pkg::result_t   | m_valid / m_ready
//
// One command at a time. Add scans the store for a free id (one entry per
// cycle, plus a rescan per id in use), then sifts up. Remove scans for the
// id, fetches the last entry, sifts it up from the hole, reloads the hole
// and sifts down. Expire and next wait read the root; expire may sift down.
// Reset is synchronous and needs no clearing pass: entries past the count
// are never used. A stalled result holds in the output register and the
// sequencer holds its finished result until that register frees.
// ----------------------------------------------------------------------------
module timer_min_heap_queue_top #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmhq_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output tmhq_pkg::result_t m_result
);
    import tmhq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);

    seq_stat_t     stat;
    result_t       seq_res;
    result_t       m_result_reg;
    logic          m_valid_reg;
    logic          out_free;
    logic          start;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    // take a beat only while the sequencer is free
    assign s_ready  = stat.idle;
    assign start    = s_valid && s_ready;
    // output register frees when empty or drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    tmhq_seq #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_i       (start),
        .item_i        (s_item),
        .out_free_i    (out_free),
        .stat_o        (stat),
        .result_o      (seq_res),
        .mem_wr_en_o   (wr_en),
        .mem_wr_addr_o (wr_addr),
        .mem_wr_data_o (wr_data),
        .mem_rd_addr_o (rd_addr),
        .mem_rd_data_i (rd_data)
    );

    tmhq_mem #(
        .DEPTH (HEAP_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // hold the result beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (stat.done) begin
            m_result_reg <= seq_res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule
